FILE: rtl/tbp_pkg.sv
// Package for the tournament branch predictor.
// Holds counter types, reset values and the saturating counter step.
// No dependencies.
package tbp_pkg;

   localparam int ADDR_W  = 32;
   localparam int COUNT_W = 32;
   localparam int CTR_W   = 2;

   typedef logic [CTR_W-1:0] ctr_type;

   localparam ctr_type CTR_MIN        = 2'd0;
   localparam ctr_type CTR_MAX        = 2'd3;
   localparam ctr_type CTR_TAKEN_MIN  = 2'd2;
   localparam ctr_type GSHARE_RESET   = 2'd3;
   localparam ctr_type BIMODAL_RESET  = 2'd3;
   localparam ctr_type CHOOSER_RESET  = 2'd0;

   // bimodal and chooser share an index, so they share one memory word
   typedef struct packed {
      ctr_type chooser;
      ctr_type bimodal;
   } local_entry_type;

   localparam int LOCAL_W = $bits(local_entry_type);

   function automatic ctr_type ctr_step(input ctr_type c, input logic up);
      ctr_type r;
      r = c;
      if (up) begin
         if (c != CTR_MAX) r = c + ctr_type'(1);
      end else begin
         if (c != CTR_MIN) r = c - ctr_type'(1);
      end
      return r;
   endfunction

endpackage

FILE: rtl/tbp_ifs.sv
// Valid/ready channel interfaces of the tournament branch predictor.
// Request carries one resolved branch, response one prediction report.
// No dependencies.
interface tbp_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] branch_address;
   logic        taken;

   modport source (output valid, output branch_address, output taken, input ready);
   modport sink   (input valid, input branch_address, input taken, output ready);
endinterface

interface tbp_rsp_if;
   logic        valid;
   logic        ready;
   logic        predicted_taken;
   logic        was_correct;
   logic        used_gshare;
   logic [31:0] correct_total;
   logic [31:0] branch_total;

   modport source (output valid, output predicted_taken, output was_correct,
                   output used_gshare, output correct_total, output branch_total,
                   input ready);
   modport sink   (input valid, input predicted_taken, input was_correct,
                   input used_gshare, input correct_total, input branch_total,
                   output ready);
endinterface

FILE: rtl/tbp_ram.sv
// Generic single-write, single-read synchronous RAM, registered read.
// Read-first on a same-address collision. No dependencies.
module tbp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/tournament_branch_predictor.sv
// Tournament branch predictor: gshare and bimodal 2-bit counter tables with a
// per-address chooser. Takes one resolved branch per cycle unless stalled;
// the report is computed in stage s1 and held in an output register.
// While a report waits, one more branch is taken in and then req_ch.ready stays
// low until the report transfers. The rate is set by one read and
// one write port per table memory: each branch reads its entries on transfer
// and writes them back when it leaves s1, with the last write forwarded to a
// following read of the same entry. After reset the block sweeps both
// memories to their reset values, with req_ch.ready low until the sweep ends.
// TABLE_ENTRIES must be a power of two.
// Depends on tbp_pkg, tbp_ifs and tbp_ram.
module tournament_branch_predictor #(
   parameter int TABLE_ENTRIES = 2048,
   parameter int HISTORY_BITS  = 11
) (
   input logic       clock,
   input logic       reset,
   tbp_req_if.sink   req_ch,
   tbp_rsp_if.source rsp_ch
);

   import tbp_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int XW    = (IDX_W > HISTORY_BITS) ? IDX_W : HISTORY_BITS;

   logic                    clr_active_ff;
   logic [IDX_W-1:0]        clr_idx_ff;
   logic [HISTORY_BITS-1:0] history_ff;
   logic [HISTORY_BITS-1:0] history_in;

   logic                    s1_valid_ff;
   logic [IDX_W-1:0]        s1_gidx_ff;
   logic [IDX_W-1:0]        s1_lidx_ff;
   logic                    s1_taken_ff;

   logic                    g_fwd_valid_ff;
   logic [IDX_W-1:0]        g_fwd_idx_ff;
   ctr_type                 g_fwd_val_ff;
   logic                    l_fwd_valid_ff;
   logic [IDX_W-1:0]        l_fwd_idx_ff;
   local_entry_type         l_fwd_val_ff;

   logic [COUNT_W-1:0]      correct_count_ff;
   logic [COUNT_W-1:0]      correct_count_in;
   logic [COUNT_W-1:0]      branch_count_ff;
   logic [COUNT_W-1:0]      branch_count_in;

   logic                    rsp_valid_ff;
   logic                    rsp_pred_ff;
   logic                    rsp_correct_ff;
   logic                    rsp_gshare_ff;
   logic [COUNT_W-1:0]      rsp_correct_total_ff;
   logic [COUNT_W-1:0]      rsp_branch_total_ff;

   logic                    s1_adv;
   logic                    s1_fire;
   logic                    req_fire;
   logic [IDX_W-1:0]        req_lidx;
   logic [IDX_W-1:0]        req_gidx;
   logic [XW-1:0]           hist_x;

   logic                    g_wr_en;
   logic [IDX_W-1:0]        g_wr_addr;
   ctr_type                 g_wr_data;
   ctr_type                 g_rd_data;
   logic                    l_wr_en;
   logic [IDX_W-1:0]        l_wr_addr;
   logic [LOCAL_W-1:0]      l_wr_data;
   logic [LOCAL_W-1:0]      l_rd_data;

   ctr_type                 g_cur;
   local_entry_type         l_cur;
   ctr_type                 g_new;
   local_entry_type         l_new;
   local_entry_type         l_reset;
   logic                    g_guess;
   logic                    b_guess;
   logic                    pick_g;
   logic                    guess;
   logic                    right;

   // handshake
   assign s1_adv       = !rsp_valid_ff || rsp_ch.ready;
   assign s1_fire      = s1_valid_ff && s1_adv;
   assign req_ch.ready = !clr_active_ff && (!s1_valid_ff || s1_adv);
   assign req_fire     = req_ch.valid && req_ch.ready;

   // indexing
   assign hist_x     = XW'(history_ff);
   assign req_lidx   = req_ch.branch_address[IDX_W-1:0];
   assign req_gidx   = IDX_W'(req_ch.branch_address[XW-1:0] ^ hist_x);
   assign history_in = {history_ff[HISTORY_BITS-2:0], req_ch.taken};

   // prediction and training, with forwarding of the last write
   always_comb begin
      g_cur = (g_fwd_valid_ff && g_fwd_idx_ff == s1_gidx_ff) ? g_fwd_val_ff : g_rd_data;
      l_cur = (l_fwd_valid_ff && l_fwd_idx_ff == s1_lidx_ff) ? l_fwd_val_ff
                                                            : local_entry_type'(l_rd_data);
      g_guess = g_cur >= CTR_TAKEN_MIN;
      b_guess = l_cur.bimodal >= CTR_TAKEN_MIN;
      pick_g  = l_cur.chooser < CTR_TAKEN_MIN;
      guess   = pick_g ? g_guess : b_guess;
      right   = guess == s1_taken_ff;
      g_new   = ctr_step(g_cur, s1_taken_ff);
      l_new.bimodal = ctr_step(l_cur.bimodal, s1_taken_ff);
      l_new.chooser = (g_guess != b_guess) ? ctr_step(l_cur.chooser, b_guess == s1_taken_ff)
                                           : l_cur.chooser;
      branch_count_in  = branch_count_ff + COUNT_W'(1);
      correct_count_in = correct_count_ff + COUNT_W'(right);
   end

   // memory ports: clearing sweep or write-back
   assign l_reset.chooser = CHOOSER_RESET;
   assign l_reset.bimodal = BIMODAL_RESET;
   assign g_wr_en   = clr_active_ff || s1_fire;
   assign g_wr_addr = clr_active_ff ? clr_idx_ff : s1_gidx_ff;
   assign g_wr_data = clr_active_ff ? GSHARE_RESET : g_new;
   assign l_wr_en   = clr_active_ff || s1_fire;
   assign l_wr_addr = clr_active_ff ? clr_idx_ff : s1_lidx_ff;
   assign l_wr_data = clr_active_ff ? l_reset : l_new;

   tbp_ram #(
      .WIDTH (CTR_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_gshare_ram (
      .clock   (clock),
      .wr_en   (g_wr_en),
      .wr_addr (g_wr_addr),
      .wr_data (g_wr_data),
      .rd_en   (req_fire),
      .rd_addr (req_gidx),
      .rd_data (g_rd_data)
   );

   tbp_ram #(
      .WIDTH (LOCAL_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_local_ram (
      .clock   (clock),
      .wr_en   (l_wr_en),
      .wr_addr (l_wr_addr),
      .wr_data (l_wr_data),
      .rd_en   (req_fire),
      .rd_addr (req_lidx),
      .rd_data (l_rd_data)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff    <= 1'b1;
         clr_idx_ff       <= '0;
         history_ff       <= '0;
         s1_valid_ff      <= 1'b0;
         g_fwd_valid_ff   <= 1'b0;
         l_fwd_valid_ff   <= 1'b0;
         correct_count_ff <= '0;
         branch_count_ff  <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (clr_active_ff) begin
            clr_idx_ff <= clr_idx_ff + IDX_W'(1);
            if (clr_idx_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
               clr_active_ff <= 1'b0;
            end
         end
         if (req_fire) begin
            history_ff  <= history_in;
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            g_fwd_valid_ff   <= 1'b1;
            l_fwd_valid_ff   <= 1'b1;
            correct_count_ff <= correct_count_in;
            branch_count_ff  <= branch_count_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_gidx_ff  <= req_gidx;
         s1_lidx_ff  <= req_lidx;
         s1_taken_ff <= req_ch.taken;
      end
      if (s1_fire) begin
         g_fwd_idx_ff         <= s1_gidx_ff;
         g_fwd_val_ff         <= g_new;
         l_fwd_idx_ff         <= s1_lidx_ff;
         l_fwd_val_ff         <= l_new;
         rsp_pred_ff          <= guess;
         rsp_correct_ff       <= right;
         rsp_gshare_ff        <= pick_g;
         rsp_correct_total_ff <= correct_count_in;
         rsp_branch_total_ff  <= branch_count_in;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.predicted_taken = rsp_pred_ff;
   assign rsp_ch.was_correct     = rsp_correct_ff;
   assign rsp_ch.used_gshare     = rsp_gshare_ff;
   assign rsp_ch.correct_total   = rsp_correct_total_ff;
   assign rsp_ch.branch_total    = rsp_branch_total_ff;

`ifndef ASSERT_OFF
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !req_ch.ready)
      else $error("transfer accepted during table clear");

   a_branch_count_step: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> branch_count_ff == $past(branch_count_ff) + COUNT_W'(1))
      else $error("branch count did not advance");

   a_correct_count_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_fire || !right |=> correct_count_ff == $past(correct_count_ff))
      else $error("correct count moved without a correct prediction");

   a_history_shift: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> history_ff[0] == $past(req_ch.taken))
      else $error("history did not shift in the outcome");

   a_report_on_fire: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff && rsp_branch_total_ff == branch_count_ff)
      else $error("report not loaded with current branch total");
`endif

endmodule
